@@ sv/bbe_pkg.sv @@
// Shared constants for the edge-clamped box blur.
`default_nettype none

package bbe_pkg;

    // Default build: largest supported radius and sample width
    localparam int MAX_RADIUS_DEF   = 31;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Width of the radius register as seen on the configuration port
    localparam int RAD_W = 5;

    // Radius after reset
    localparam int RADIUS_RESET = 1;

endpackage

`default_nettype wire

@@ sv/box_blur_edge_clamped.sv @@
// Top level of the edge-clamped box blur over a streamed height profile.
`default_nettype none

// Each output is the mean of the 2*radius+1 samples around its position, with
// positions before the start reading the first sample and positions past the end
// reading the last one, truncated toward zero; outputs trail inputs by radius
// samples and the beat with tlast flushes the rest, the final one with tlast set.
// A sample that yields no output leaves the block ready for the next one. Each
// output's sum token walks the cell chain, its quotient is then formed in the
// serial divider and loaded into the output register. A sample is taken only
// when the previous one has issued all of its outputs; the last output may still
// wait in the output register. Radius writes are saturated to MAX_RADIUS.

module box_blur_edge_clamped #(
    parameter  int MAX_RADIUS   = bbe_pkg::MAX_RADIUS_DEF,
    parameter  int SAMPLE_WIDTH = bbe_pkg::SAMPLE_WIDTH_DEF,
    localparam int TDATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // Radius register write
    input  wire logic                      i_cfg_we,
    input  wire logic [bbe_pkg::RAD_W-1:0] i_cfg_wdata,
    // Sample stream
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [TDATA_W-1:0]        s_axis_tdata,   // height
    input  wire logic                      s_axis_tlast,   // last
    // Blurred stream
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic [TDATA_W-1:0]             m_axis_tdata,   // blurred
    output logic                           m_axis_tlast    // last_out
);

    import bbe_pkg::*;

    localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;
    localparam int LIM_W     = $clog2(WIN_DEPTH);
    localparam int SEEN_W    = $clog2(WIN_DEPTH + 1);
    localparam int SUM_W     = SAMPLE_WIDTH + $clog2(WIN_DEPTH);
    localparam int DIV_W     = RAD_W + 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ISSUE = 5'b00010,
        S_CHAIN = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state                         r_state, n_state;
    logic        [RAD_W-1:0]        r_radius;
    logic        [SEEN_W-1:0]       r_seen;
    logic signed [SAMPLE_WIDTH-1:0] r_first;
    logic        [RAD_W-1:0]        r_d;
    logic                           r_flush;
    logic                           r_tok_valid;
    logic signed [SUM_W-1:0]        r_tok_sum;
    logic        [LIM_W-1:0]        r_tok_lim;
    logic                           r_ovalid;
    logic        [SAMPLE_WIDTH-1:0] r_odata;
    logic                           r_olast;

    logic                           w_in_acc;
    logic signed [SAMPLE_WIDTH-1:0] w_sample;
    logic        [SEEN_W-1:0]       w_seen_inc;
    logic                           w_need;
    logic        [RAD_W-1:0]        w_d_start;
    logic        [RAD_W:0]          w_w0;
    logic signed [SUM_W-1:0]        w_prod;
    logic                           w_oload;
    logic                           w_final;
    logic                           w_div_start;
    logic                           w_div_done;
    logic        [SAMPLE_WIDTH-1:0] w_quot;

    // Chain wiring: index k feeds cell k, cell k drives index k+1
    logic signed [SAMPLE_WIDTH-1:0] w_samp [0:WIN_DEPTH];
    logic                           w_tv   [0:WIN_DEPTH];
    logic signed [SUM_W-1:0]        w_ts   [0:WIN_DEPTH];
    logic        [LIM_W-1:0]        w_tl   [0:WIN_DEPTH];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_sample      = s_axis_tdata[SAMPLE_WIDTH-1:0];

    // Sample count saturates once the whole window is covered
    assign w_seen_inc = (r_seen == SEEN_W'(WIN_DEPTH)) ? r_seen : r_seen + SEEN_W'(1);

    // Plan outputs for this beat: one centered output, or a flush from the oldest
    assign w_need = s_axis_tlast || (int'(w_seen_inc) > int'(r_radius));
    always_comb begin
        w_d_start = r_radius;
        if (s_axis_tlast && (int'(w_seen_inc) - 1 < int'(r_radius))) begin
            w_d_start = RAD_W'(w_seen_inc - SEEN_W'(1));
        end
    end

    // Newest tap counts once per window position clamped onto it
    assign w_w0   = {1'b0, r_radius} - {1'b0, r_d} + DIV_W'(1);
    assign w_prod = $signed({{(SUM_W-DIV_W){1'b0}}, w_w0})
                  * $signed({{(SUM_W-SAMPLE_WIDTH){w_samp[1][SAMPLE_WIDTH-1]}}, w_samp[1]});

    assign w_oload     = (r_state == S_OUT) && (!r_ovalid || m_axis_tready);
    assign w_final     = !r_flush || (r_d == '0);
    assign w_div_start = (r_state == S_CHAIN) && w_tv[WIN_DEPTH];

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && w_need) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                n_state = S_CHAIN;
            end
            S_CHAIN: begin
                if (w_tv[WIN_DEPTH]) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_oload) begin
                    n_state = w_final ? S_IDLE : S_ISSUE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Radius register, saturated to the build limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RAD_W'(RADIUS_RESET);
        end else if (i_cfg_we) begin
            if (int'(i_cfg_wdata) > MAX_RADIUS) begin
                r_radius <= RAD_W'(MAX_RADIUS);
            end else begin
                r_radius <= i_cfg_wdata;
            end
        end
    end

    // Profile state: count, first sample, output position and flush mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_flush <= 1'b0;
            r_d     <= '0;
        end else begin
            if (w_in_acc) begin
                r_seen  <= w_seen_inc;
                r_flush <= s_axis_tlast;
                r_d     <= w_d_start;
            end else if (w_oload) begin
                if (w_final) begin
                    if (r_flush) begin
                        r_seen <= '0;
                    end
                end else begin
                    r_d <= r_d - RAD_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (r_seen == '0)) begin
            r_first <= w_sample;
        end
    end

    // Inject one sum token per output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_valid <= 1'b0;
        end else begin
            r_tok_valid <= (r_state == S_ISSUE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok_sum <= w_prod;
        r_tok_lim <= LIM_W'({1'b0, r_d} + {1'b0, r_radius});
    end

    assign w_samp[0] = w_sample;
    assign w_tv[0]   = r_tok_valid;
    assign w_ts[0]   = r_tok_sum;
    assign w_tl[0]   = r_tok_lim;

    // Window taps, newest first
    for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_cell
        bbe_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .SUM_W        (SUM_W),
            .LIM_W        (LIM_W),
            .SEEN_W       (SEEN_W),
            .INDEX        (k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_shift     (w_in_acc),
            .i_sample    (w_samp[k]),
            .o_sample    (w_samp[k+1]),
            .i_seen      (r_seen),
            .i_first     (r_first),
            .i_tok_valid (w_tv[k]),
            .i_tok_sum   (w_ts[k]),
            .i_tok_lim   (w_tl[k]),
            .o_tok_valid (w_tv[k+1]),
            .o_tok_sum   (w_ts[k+1]),
            .o_tok_lim   (w_tl[k+1])
        );
    end

    // Divide the finished sum by the window length
    bbe_div #(
        .SUM_W (SUM_W),
        .DIV_W (DIV_W),
        .Q_W   (SAMPLE_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_ts[WIN_DEPTH]),
        .i_divisor  ({r_radius, 1'b1}),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // Output register: hold the beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_oload) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_oload) begin
            r_odata <= w_quot;
            r_olast <= r_flush && (r_d == '0);
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = TDATA_W'(r_odata);
    assign m_axis_tlast  = r_olast;

endmodule

`default_nettype wire

@@ sv/bbe_cell.sv @@
// One cell of the sample chain: holds one window tap and one stage of the sum token.
`default_nettype none

module bbe_cell #(
    parameter int SAMPLE_WIDTH = bbe_pkg::SAMPLE_WIDTH_DEF,
    parameter int SUM_W        = 22,
    parameter int LIM_W        = 6,
    parameter int SEEN_W       = 6,
    parameter int INDEX        = 0
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Sample shift from the newer neighbor
    input  wire logic                           i_shift,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic signed [SAMPLE_WIDTH-1:0]      o_sample,
    // Profile state broadcast to every cell
    input  wire logic        [SEEN_W-1:0]       i_seen,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_first,
    // Sum token from the newer neighbor
    input  wire logic                           i_tok_valid,
    input  wire logic signed [SUM_W-1:0]        i_tok_sum,
    input  wire logic        [LIM_W-1:0]        i_tok_lim,
    // Sum token to the older neighbor
    output logic                                o_tok_valid,
    output logic signed [SUM_W-1:0]             o_tok_sum,
    output logic        [LIM_W-1:0]             o_tok_lim
);

    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic                           r_tok_valid;
    logic signed [SUM_W-1:0]        r_tok_sum;
    logic        [LIM_W-1:0]        r_tok_lim;

    logic                           w_use;
    logic signed [SAMPLE_WIDTH-1:0] w_tap;
    logic signed [SUM_W-1:0]        w_add;

    // Tap zero is weighted at injection; others count once when inside the window
    assign w_use = (INDEX != 0) && (LIM_W'(INDEX) <= i_tok_lim);

    // Taps older than the profile start read as the first sample
    assign w_tap = (SEEN_W'(INDEX) < i_seen) ? r_sample : i_first;
    assign w_add = w_use ? {{(SUM_W-SAMPLE_WIDTH){w_tap[SAMPLE_WIDTH-1]}}, w_tap}
                         : '0;

    // Advance the window on each accepted sample
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sample <= i_sample;
        end
    end

    // Token valid travels one cell per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_valid <= 1'b0;
        end else begin
            r_tok_valid <= i_tok_valid;
        end
    end

    // Accumulate this tap into the passing token
    always_ff @(posedge i_clk) begin
        r_tok_sum <= i_tok_sum + w_add;
        r_tok_lim <= i_tok_lim;
    end

    assign o_sample    = r_sample;
    assign o_tok_valid = r_tok_valid;
    assign o_tok_sum   = r_tok_sum;
    assign o_tok_lim   = r_tok_lim;

endmodule

`default_nettype wire

@@ sv/bbe_div.sv @@
// Serial restoring divider: signed sum over odd window length, truncated toward zero.
`default_nettype none

module bbe_div #(
    parameter int SUM_W = 22,
    parameter int DIV_W = 6,
    parameter int Q_W   = bbe_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [SUM_W-1:0] i_dividend,
    input  wire logic        [DIV_W-1:0] i_divisor,
    output logic                         o_done,
    output logic             [Q_W-1:0]   o_quot
);

    localparam int CNT_W = $clog2(SUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic [SUM_W-1:0] r_quo;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_div;

    logic [DIV_W:0]   w_trial;
    logic             w_fit;
    logic [DIV_W:0]   w_diff;
    logic [SUM_W-1:0] w_mag;
    logic [SUM_W-1:0] w_res;

    // Magnitude of the dividend
    assign w_mag = i_dividend[SUM_W-1] ? (~i_dividend + SUM_W'(1)) : i_dividend;

    // One quotient bit per cycle
    assign w_trial = {r_rem, r_quo[SUM_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    // Control: busy while the quotient bits shift in, then a one-cycle done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    // Datapath: shift dividend out, quotient in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= w_mag;
            r_rem <= '0;
            r_neg <= i_dividend[SUM_W-1];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], w_fit};
            r_rem <= w_fit ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
        end
    end

    // Restore the sign
    assign w_res  = r_neg ? (~r_quo + SUM_W'(1)) : r_quo;
    assign o_quot = w_res[Q_W-1:0];
    assign o_done = r_done;

endmodule

`default_nettype wire

@@ sv/bbe_checker.sv @@
// Port-level checks for the box blur, bound to the top level.
`default_nettype none

module bbe_checker #(
    parameter  int SAMPLE_WIDTH = bbe_pkg::SAMPLE_WIDTH_DEF,
    localparam int TDATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               s_axis_tvalid,
    input wire logic               s_axis_tready,
    input wire logic               s_axis_tlast,
    input wire logic               m_axis_tvalid,
    input wire logic               m_axis_tready,
    input wire logic [TDATA_W-1:0] m_axis_tdata,
    input wire logic               m_axis_tlast
);

    // Hold a stalled output beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output beat changed");

    // Come out of reset ready for a sample with nothing pending
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready && !m_axis_tvalid)
        else $error("reset did not clear the block");

    // A closing sample always starts a flush, so the input side stalls
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("sample taken right after the closing sample");

    // A fresh output beat never appears right after a sample is taken
    a_no_out_after_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("output beat appeared right after a sample was taken");

endmodule

bind box_blur_edge_clamped bbe_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_bbe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

@@ test/testbench.sv @@
// Self-checking stream testbench for the edge-clamped box blur.
`default_nettype none

module testbench;

    import bbe_pkg::*;

    localparam int TDATA_W   = ((SAMPLE_WIDTH_DEF + 7) / 8) * 8;
    localparam int HIST_LEN  = 2 * MAX_RADIUS_DEF + 1;
    localparam int SEEN_SAT  = 65535;
    // Settle time after the last expected beat
    localparam int SETTLE    = 150;
    localparam int CYCLE_CAP = 4000000;
    localparam int RANDOM_TARGET = 340;

    typedef struct {
        logic signed [15:0] height;
        logic               last;
    } t_sample_beat;

    typedef struct {
        logic signed [15:0] blurred;
        logic               last_out;
    } t_blur_beat;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [RAD_W-1:0]   i_cfg_wdata = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata = '0;   // height
    logic               s_axis_tlast = 1'b0; // last
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;        // blurred
    logic               m_axis_tlast;        // last_out

    box_blur_edge_clamped dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Stimulus and expectation stores
    t_sample_beat sample_q[$];
    t_blur_beat   blurred_q[$];

    // Predictor state
    logic signed [15:0] profile_hist [HIST_LEN];
    logic signed [15:0] profile_first;
    int                 hist_count;
    int                 blur_radius;

    // Bookkeeping
    int beats_queued;
    int beats_taken;
    int outputs_checked;
    int mismatch_count;
    int profiles_closed;
    int radius_writes;
    int cycle_count;
    int in_gap;
    int out_gap;
    int idle_odds;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Mean of the window centered pos samples back from the newest one
    function automatic logic signed [15:0] window_mean(int pos, int r);
        longint acc;
        int     t;
        int     k;
        acc = 0;
        for (t = -r; t <= r; t++) begin
            k = pos + t;
            if (k < 0) k = 0;
            if (k > HIST_LEN - 1) k = HIST_LEN - 1;
            if (k >= hist_count)
                acc += longint'(profile_first);
            else
                acc += longint'(profile_hist[k]);
        end
        return 16'(acc / longint'(2 * r + 1));
    endfunction

    task automatic push_blurred(logic signed [15:0] value, logic fin);
        t_blur_beat b;
        b.blurred  = value;
        b.last_out = fin;
        blurred_q.push_back(b);
    endtask

    // Advance the profile by one sample and queue the outputs it releases
    task automatic predict_blur(logic signed [15:0] height, logic last);
        int r;
        int k;
        int back;
        r = blur_radius;
        if (hist_count == 0) profile_first = height;
        for (k = HIST_LEN - 1; k > 0; k--) profile_hist[k] = profile_hist[k - 1];
        profile_hist[0] = height;
        if (hist_count < SEEN_SAT) hist_count++;
        if (!last) begin
            if (hist_count > r) push_blurred(window_mean(r, r), 1'b0);
        end else begin
            back = (hist_count - 1 < r) ? hist_count - 1 : r;
            for (; back >= 0; back--) push_blurred(window_mean(back, r), back == 0);
            // Drop all profile state
            for (k = 0; k < HIST_LEN; k++) profile_hist[k] = '0;
            profile_first = '0;
            hist_count = 0;
            profiles_closed++;
        end
    endtask

    // Sample driver: take accepted beats into the predictor, then refill
    always @(posedge i_clk) begin
        t_sample_beat nxt;
        if (i_cfg_we)
            blur_radius = (int'(i_cfg_wdata) > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF
                                                              : int'(i_cfg_wdata);
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_blur(s_axis_tdata[15:0], s_axis_tlast);
                beats_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (sample_q.size() != 0 && idle_odds != 0 &&
                             $urandom_range(0, idle_odds - 1) == 0) begin
                    in_gap = $urandom_range(0, 8);
                    s_axis_tvalid <= 1'b0;
                end else if (sample_q.size() != 0) begin
                    nxt = sample_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.height;
                    s_axis_tlast  <= nxt.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: check each beat against the oldest expectation, stall at random
    always @(posedge i_clk) begin
        t_blur_beat exp_b;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (blurred_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected output beat blurred=%0d last=%0b", $time,
                             $signed(m_axis_tdata[15:0]), m_axis_tlast);
                end else begin
                    exp_b = blurred_q.pop_front();
                    outputs_checked++;
                    if (m_axis_tdata[15:0] !== exp_b.blurred) begin
                        mismatch_count++;
                        $display("%0t: blurred expected %0d actual %0d", $time,
                                 exp_b.blurred, $signed(m_axis_tdata[15:0]));
                    end
                    if (m_axis_tlast !== exp_b.last_out) begin
                        mismatch_count++;
                        $display("%0t: last_out expected %0b actual %0b", $time,
                                 exp_b.last_out, m_axis_tlast);
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                m_axis_tready <= 1'b0;
            end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
                out_gap = $urandom_range(0, 8);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_CAP) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL box_blur_edge_clamped");
        $finish;
    end

    task automatic queue_sample(logic signed [15:0] height, logic last);
        t_sample_beat s;
        s.height = height;
        s.last   = last;
        sample_q.push_back(s);
        beats_queued++;
    endtask

    // Hold until every sample is taken and every output checked, then settle
    task automatic drain();
        while (!(beats_taken == beats_queued && blurred_q.size() == 0))
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_radius(int r);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= RAD_W'(r);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        radius_writes++;
    endtask

    function automatic logic signed [15:0] random_height();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'($signed($urandom_range(0, 20)) - 10);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int k;
        int phase;
        int r;
        int phase_items;
        int placed;
        int len;
        int random_total;
        bit final_phase;
        bit leave_open;

        for (k = 0; k < HIST_LEN; k++) profile_hist[k] = '0;
        profile_first   = '0;
        hist_count      = 0;
        blur_radius     = RADIUS_RESET;
        beats_queued    = 0;
        beats_taken     = 0;
        outputs_checked = 0;
        mismatch_count  = 0;
        profiles_closed = 0;
        radius_writes   = 0;
        in_gap          = 0;
        out_gap         = 0;
        idle_odds       = 6;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset radius: field extremes, then a one-sample profile
        queue_sample(16'sh7fff, 1'b0);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh7fff, 1'b1);
        queue_sample(16'sh8000, 1'b1);
        drain();

        // Radius zero passes samples through, negative values included
        write_radius(0);
        queue_sample(16'sd5, 1'b0);
        queue_sample(-16'sd7, 1'b0);
        queue_sample(16'sd100, 1'b1);
        drain();

        // Widest window over profiles far shorter than it
        write_radius(MAX_RADIUS_DEF);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh8000, 1'b1);
        queue_sample(16'sh7fff, 1'b0);
        queue_sample(16'sh7fff, 1'b1);
        drain();

        // Grow the radius in the middle of a profile
        write_radius(3);
        queue_sample(-16'sd1, 1'b0);
        queue_sample(-16'sd2, 1'b0);
        queue_sample(-16'sd3, 1'b0);
        queue_sample(-16'sd4, 1'b0);
        drain();
        write_radius(5);
        queue_sample(-16'sd5, 1'b0);
        queue_sample(16'sd7, 1'b1);
        drain();

        // Shrink the radius in the middle of a profile
        write_radius(6);
        queue_sample(16'sd9, 1'b0);
        queue_sample(-16'sd9, 1'b0);
        queue_sample(16'sd9, 1'b0);
        queue_sample(-16'sd9, 1'b0);
        queue_sample(16'sd9, 1'b0);
        drain();
        write_radius(1);
        queue_sample(16'sd4, 1'b1);
        drain();

        // Random profiles, one radius per phase, some phases end mid-profile
        random_total = 0;
        phase = 0;
        while (random_total < RANDOM_TARGET) begin
            case (phase % 4)
                0:       r = 0;
                1:       r = MAX_RADIUS_DEF;
                default: r = $urandom_range(0, MAX_RADIUS_DEF);
            endcase
            phase_items = $urandom_range(20, 50);
            final_phase = (random_total + phase_items >= RANDOM_TARGET);
            idle_odds = final_phase ? 0 : (($urandom_range(0, 3) == 0) ? 0 : 6);
            write_radius(r);
            placed = 0;
            while (placed < phase_items) begin
                len = $urandom_range(1, 2 * r + 6);
                if (len > 40) len = $urandom_range(20, 40);
                leave_open = (placed + len >= phase_items) && !final_phase &&
                             ($urandom_range(0, 3) == 0);
                for (k = 0; k < len; k++)
                    queue_sample(random_height(), (k == len - 1) && !leave_open);
                placed += len;
            end
            random_total += placed;
            drain();
            phase++;
        end

        $display("Covered %0d samples over %0d closed profiles and %0d radius writes;",
                 beats_taken, profiles_closed, radius_writes);
        $display("checked %0d blurred outputs, %0d mismatches.", outputs_checked,
                 mismatch_count);
        if (mismatch_count == 0)
            $display("PASS box_blur_edge_clamped");
        else
            $display("FAIL box_blur_edge_clamped");
        $finish;
    end

endmodule

`default_nettype wire
